/* sv/pntt_pkg.sv */
// Package: widths, codes and the sequencer control store of the cached tally block.
`default_nettype none
package pntt_pkg;

   localparam int TABLE_SLOTS_DEFAULT = 64;
   localparam int NUM_NODES_W         = 7;
   localparam int NODE_ID_W           = 8;
   localparam int COUNT_W             = 16;
   localparam int CSR_ADDR_W          = 2;
   localparam int CSR_DATA_W          = 32;

   localparam logic [COUNT_W-1:0]     COUNT_MAX       = '1;
   localparam logic [NUM_NODES_W-1:0] NONZERO_MAX     = '1;
   localparam logic [NUM_NODES_W-1:0] NUM_NODES_RESET = NUM_NODES_W'(1);

   // register byte addresses
   localparam logic [CSR_ADDR_W-1:0] ADDR_NUM_NODES = CSR_ADDR_W'(0);

   typedef enum logic {
      OP_OPEN  = 1'b0,
      OP_CLOSE = 1'b1
   } op_type;

   typedef enum logic {
      STATUS_OK   = 1'b0,
      STATUS_MISS = 1'b1
   } status_type;

   typedef enum logic [2:0] {
      STEP_IDLE = 3'b001,
      STEP_SCAN = 3'b010,
      STEP_DONE = 3'b100
   } step_type;

   // one control word per step: unit enables and the three branch targets
   typedef struct packed {
      logic     accept_en;
      logic     scan_en;
      logic     emit_en;
      step_type on_stay;
      step_type on_go;
      step_type on_fail;
   } ctrl_word_type;

   function automatic ctrl_word_type ctrl_rom(input step_type step);
      ctrl_word_type word;
      unique case (step)
         STEP_IDLE: word = '{1'b1, 1'b0, 1'b0, STEP_IDLE, STEP_SCAN, STEP_DONE};
         STEP_SCAN: word = '{1'b0, 1'b1, 1'b0, STEP_SCAN, STEP_DONE, STEP_DONE};
         STEP_DONE: word = '{1'b0, 1'b0, 1'b1, STEP_DONE, STEP_IDLE, STEP_DONE};
         default:   word = '{1'b0, 1'b0, 1'b0, STEP_IDLE, STEP_IDLE, STEP_IDLE};
      endcase
      return word;
   endfunction

endpackage
`default_nettype wire

/* sv/pntt_ifs.sv */
// Interfaces: request and response channels of the cached tally block.
`default_nettype none
interface pntt_req_if;
   import pntt_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 operation;
   logic [NODE_ID_W-1:0] node_id;
   modport source (output valid, operation, node_id, input ready);
   modport sink   (input valid, operation, node_id, output ready);
endinterface

interface pntt_rsp_if;
   logic valid;
   logic ready;
   logic status;
   logic all_nodes_cached;
   modport source (output valid, status, all_nodes_cached, input ready);
   modport sink   (input valid, status, all_nodes_cached, output ready);
endinterface
`default_nettype wire

/* sv/per_node_cached_tx_tally_top.sv */
// Top level: per-node cached transaction tally with a microcoded slot scan.
//
//   channel   dir   handshake                 payload
//   req_ch    in    valid / ready             operation, node_id
//   rsp_ch    out   valid / ready             status, all_nodes_cached
//   csr       in    psel / penable / pready   paddr, pwdata, prdata (num_nodes)
//
// A request takes an accept step, one scan step per slot searched (up to
// min(num_nodes, TABLE_SLOTS), stopping at the first match, or for an open
// at the first free slot) and a step that loads the response register. The
// slot scan reads the slot memory once a cycle. Rejected requests skip the scan.
// Reset is synchronous and clears the slot valid bits at once; no sweep.
// A pending response does not block the next request; a stalled response
// holds the sequencer in its final step until the register frees.
`default_nettype none
module per_node_cached_tx_tally_top #(
   parameter int TABLE_SLOTS = pntt_pkg::TABLE_SLOTS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   pntt_req_if.sink                                 req_ch,
   pntt_rsp_if.source                               rsp_ch,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [pntt_pkg::CSR_ADDR_W-1:0]     paddr,
   input  wire logic [pntt_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic      [pntt_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                     pready
);
   import pntt_pkg::*;

   localparam int IDX_W  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int LIM_W  = $clog2(TABLE_SLOTS + 1);
   localparam int CMP_W  = (LIM_W > NUM_NODES_W) ? LIM_W : NUM_NODES_W;
   localparam int ENTRY_W = NODE_ID_W + COUNT_W;

   // configuration
   logic [NUM_NODES_W-1:0] num_nodes_ff, num_nodes_in;
   logic                   csr_write;

   // sequencer
   step_type      step_ff, step_in;
   ctrl_word_type ctrl;
   logic          go, fail;

   // request registers
   op_type               op_ff, op_in;
   logic [NODE_ID_W-1:0] id_ff, id_in;
   logic                 req_fire, id_ok;

   // scan datapath
   logic [IDX_W-1:0] index_ff, index_in;
   logic [CMP_W-1:0] limit, idx_plus1;
   logic             last;
   logic [IDX_W-1:0] rd_addr;

   // slot memory and valid bits
   logic [ENTRY_W-1:0]   slot_mem [TABLE_SLOTS];
   logic [TABLE_SLOTS-1:0] slot_valid_ff, slot_valid_in;
   logic [ENTRY_W-1:0]   rd_data_ff;
   logic                 rd_valid_ff;
   logic [NODE_ID_W-1:0] rd_node;
   logic [COUNT_W-1:0]   rd_count, new_count;
   logic                 node_match, claim, hit, mem_we;
   logic [ENTRY_W-1:0]   wr_data;

   logic [NUM_NODES_W-1:0] nonzero_ff, nonzero_in;
   status_type             status_ff, status_in;

   // response register
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_status_ff, rsp_status_in;
   logic rsp_all_ff, rsp_all_in;
   logic out_free;

   // ---------------- configuration port ----------------
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;

   always_comb begin
      num_nodes_in = num_nodes_ff;
      if (csr_write && paddr == ADDR_NUM_NODES) begin
         num_nodes_in = pwdata[NUM_NODES_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr == ADDR_NUM_NODES) begin
         prdata = CSR_DATA_W'(num_nodes_ff);
      end
   end

   // ---------------- sequencer ----------------
   assign ctrl         = ctrl_rom(step_ff);
   assign req_ch.ready = ctrl.accept_en;
   assign req_fire     = req_ch.valid & req_ch.ready;

   assign limit = (CMP_W'(num_nodes_ff) > CMP_W'(TABLE_SLOTS)) ?
                  CMP_W'(TABLE_SLOTS) : CMP_W'(num_nodes_ff);
   assign id_ok = (req_ch.node_id != '0) && (limit != '0);

   assign idx_plus1 = CMP_W'(index_ff) + CMP_W'(1);
   assign last      = (idx_plus1 == limit);

   assign out_free = ~rsp_valid_ff | rsp_ch.ready;

   assign go   = (ctrl.accept_en & req_fire & id_ok) |
                 (ctrl.scan_en & hit) |
                 (ctrl.emit_en & out_free);
   assign fail = (ctrl.accept_en & req_fire & ~id_ok) |
                 (ctrl.scan_en & ~hit & last);

   always_comb begin
      priority if (fail) begin
         step_in = ctrl.on_fail;
      end else if (go) begin
         step_in = ctrl.on_go;
      end else begin
         step_in = ctrl.on_stay;
      end
   end

   // ---------------- scan datapath ----------------
   assign rd_node  = rd_data_ff[ENTRY_W-1:COUNT_W];
   assign rd_count = rd_data_ff[COUNT_W-1:0];

   assign node_match = rd_valid_ff && (rd_node == id_ff);
   assign claim      = ~rd_valid_ff && (op_ff == OP_OPEN);
   assign hit        = node_match | claim;
   assign mem_we     = ctrl.scan_en & hit;

   always_comb begin
      new_count = rd_count;
      if (op_ff == OP_OPEN) begin
         if (rd_count != '0) new_count = rd_count - COUNT_W'(1);
      end else begin
         if (rd_count != COUNT_MAX) new_count = rd_count + COUNT_W'(1);
      end
   end

   assign wr_data = claim ? {id_ff, COUNT_W'(0)} : {rd_node, new_count};

   // prefetch the next slot while the current one is checked
   always_comb begin
      rd_addr = index_ff;
      if (ctrl.accept_en) begin
         rd_addr = '0;
      end else if (ctrl.scan_en && !last) begin
         rd_addr = idx_plus1[IDX_W-1:0];
      end
   end

   always_comb begin
      op_in         = op_ff;
      id_in         = id_ff;
      index_in      = index_ff;
      status_in     = status_ff;
      nonzero_in    = nonzero_ff;
      slot_valid_in = slot_valid_ff;
      if (ctrl.accept_en && req_fire) begin
         op_in     = op_type'(req_ch.operation);
         id_in     = req_ch.node_id;
         index_in  = '0;
         status_in = id_ok ? STATUS_OK : STATUS_MISS;
      end
      if (ctrl.scan_en) begin
         if (hit) begin
            status_in = STATUS_OK;
            if (claim) begin
               slot_valid_in[index_ff] = 1'b1;
            end else if (op_ff == OP_OPEN) begin
               if (rd_count == COUNT_W'(1) && nonzero_ff != '0) begin
                  nonzero_in = nonzero_ff - NUM_NODES_W'(1);
               end
            end else begin
               if (rd_count == '0 && nonzero_ff != NONZERO_MAX) begin
                  nonzero_in = nonzero_ff + NUM_NODES_W'(1);
               end
            end
         end else if (last) begin
            status_in = STATUS_MISS;
         end else begin
            index_in = idx_plus1[IDX_W-1:0];
         end
      end
   end

   // ---------------- response register ----------------
   always_comb begin
      rsp_valid_in  = rsp_valid_ff & ~rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_all_in    = rsp_all_ff;
      if (ctrl.emit_en && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_all_in    = (nonzero_ff == num_nodes_ff);
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.status           = rsp_status_ff;
   assign rsp_ch.all_nodes_cached = rsp_all_ff;

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         num_nodes_ff  <= NUM_NODES_RESET;
         step_ff       <= STEP_IDLE;
         nonzero_ff    <= '0;
         slot_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         num_nodes_ff  <= num_nodes_in;
         step_ff       <= step_in;
         nonzero_ff    <= nonzero_in;
         slot_valid_ff <= slot_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      id_ff         <= id_in;
      index_ff      <= index_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_all_ff    <= rsp_all_in;
   end

   // slot memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[index_ff] <= wr_data;
      end
      rd_data_ff  <= slot_mem[rd_addr];
      rd_valid_ff <= slot_valid_in[rd_addr] & slot_valid_ff[rd_addr];
   end

endmodule
`default_nettype wire

/* bench/tb.sv */
// Testbench for the per-node cached transaction tally: directed, random and back-to-back runs.
module tb;
   import pntt_pkg::*;

   localparam int TABLE_SLOTS       = TABLE_SLOTS_DEFAULT;
   localparam int CLOCK_PERIOD      = 12;
   localparam int RUN_LIMIT_CYCLES  = 3_000_000;
   localparam int LONG_STALL_CYCLES = 400;
   localparam int RANDOM_PER_PHASE  = 100;
   localparam int TAIL_CLOSES       = 16;
   localparam int ERROR_PRINT_CAP   = 30;

   typedef struct packed {
      status_type status;
      logic       all_cached;
   } tally_result_type;

   // Tracks the slot table and the expected responses in request order.
   class tally_scoreboard_type;
      logic [NODE_ID_W-1:0]   slot_node [TABLE_SLOTS];
      logic [COUNT_W-1:0]     slot_count[TABLE_SLOTS];
      logic [NUM_NODES_W-1:0] nonzero_nodes;
      logic [NUM_NODES_W-1:0] num_nodes;
      tally_result_type       pending[$];
      int                     errors;

      function new();
         foreach (slot_node[i]) begin
            slot_node[i]  = '0;
            slot_count[i] = '0;
         end
         nonzero_nodes = '0;
         num_nodes     = NUM_NODES_RESET;
         errors        = 0;
      endfunction

      function void report(string field, int want, int got);
         if (errors < ERROR_PRINT_CAP)
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
         errors++;
      endfunction

      function void note_request(op_type op, logic [NODE_ID_W-1:0] id);
         int               i;
         int               limit;
         bit               found;
         tally_result_type want;
         want.status = STATUS_MISS;
         found = 1'b0;
         limit = (num_nodes > TABLE_SLOTS) ? TABLE_SLOTS : int'(num_nodes);
         // node id zero marks an empty slot and is never searched
         if (id != '0) begin
            for (i = 0; i < limit && !found; i++) begin
               if (slot_node[i] == id) begin
                  found = 1'b1;
                  want.status = STATUS_OK;
                  if (op == OP_OPEN) begin
                     if (slot_count[i] != '0) begin
                        slot_count[i]--;
                        if (slot_count[i] == '0 && nonzero_nodes != '0)
                           nonzero_nodes--;
                     end
                  end else if (slot_count[i] != COUNT_MAX) begin
                     slot_count[i]++;
                     if (slot_count[i] == COUNT_W'(1) && nonzero_nodes != NONZERO_MAX)
                        nonzero_nodes++;
                  end
               end else if (slot_node[i] == '0 && op == OP_OPEN) begin
                  // claim the first free slot, count stays as is
                  found = 1'b1;
                  want.status = STATUS_OK;
                  slot_node[i] = id;
               end
            end
         end
         want.all_cached = (nonzero_nodes == num_nodes);
         pending.push_back(want);
      endfunction

      function void check_response(logic status, logic all_cached);
         tally_result_type want;
         if (pending.size() == 0) begin
            if (errors < ERROR_PRINT_CAP)
               $error("response with no request outstanding: status %0d", status);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (status !== want.status)
            report("status", int'(want.status), int'(status));
         if (all_cached !== want.all_cached)
            report("all_nodes_cached", int'(want.all_cached), int'(all_cached));
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   pntt_req_if req_ch ();
   pntt_rsp_if rsp_ch ();

   per_node_cached_tx_tally_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   tally_scoreboard_type sb = new();

   int burst_left         = 4;
   bit paced_sender       = 1'b1;
   bit fast_drain         = 1'b0;
   bit long_stall_armed   = 1'b0;
   bit long_stall_done    = 1'b0;
   int random_settings[5] = '{3, 6, 64, 127, 33};

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT_CYCLES * CLOCK_PERIOD);
      $display("TEST FAILED");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_response(rsp_ch.status, rsp_ch.all_nodes_cached);
         if (req_ch.valid && req_ch.ready)
            sb.note_request(op_type'(req_ch.operation), req_ch.node_id);
      end
   end

   // Response side: random stall patterns, one long hold-off when armed.
   initial begin : rsp_pacer
      int mode;
      int span;
      forever begin
         if (long_stall_armed && !long_stall_done) begin
            long_stall_done = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (LONG_STALL_CYCLES) @(posedge clock);
         end
         mode = fast_drain ? 0 : $urandom_range(0, 3);
         span = $urandom_range(4, 40);
         repeat (span) begin
            case (mode)
               0: rsp_ch.ready <= 1'b1;
               1: rsp_ch.ready <= 1'($urandom_range(0, 1));
               2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            endcase
            @(posedge clock);
         end
      end
   end

   task automatic send_request(input op_type op, input logic [NODE_ID_W-1:0] id);
      int gap;
      req_ch.valid     <= 1'b1;
      req_ch.operation <= op;
      req_ch.node_id   <= id;
      do @(posedge clock); while (!req_ch.ready);
      if (paced_sender) begin
         if (burst_left > 0)
            burst_left--;
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 6);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 8);
         end
      end
   endtask

   task automatic drain_tally();
      if (req_ch.valid)
         req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Write num_nodes while idle, with junk in the unused upper bits, then read it back.
   task automatic set_num_nodes(input logic [NUM_NODES_W-1:0] value);
      drain_tally();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_NUM_NODES;
      pwdata  <= ($urandom << NUM_NODES_W) | CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.num_nodes = value;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[NUM_NODES_W-1:0] !== value)
         sb.report("num_nodes readback", int'(value), int'(prdata[NUM_NODES_W-1:0]));
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Favor ids already held in the searched slots so counts build up.
   function automatic logic [NODE_ID_W-1:0] pick_node_id();
      int roll;
      int limit;
      int k;
      roll  = $urandom_range(0, 99);
      limit = (sb.num_nodes > TABLE_SLOTS) ? TABLE_SLOTS : int'(sb.num_nodes);
      if (roll < 4)
         return '0;
      if (roll < 8)
         return '1;
      if (roll < 78 && limit > 0) begin
         k = $urandom_range(0, limit - 1);
         if (sb.slot_node[k] != '0)
            return sb.slot_node[k];
      end
      return NODE_ID_W'($urandom_range(1, 255));
   endfunction

   initial begin : stimulus
      int phase;
      int n;
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.operation <= OP_OPEN;
      req_ch.node_id   <= '0;
      psel             <= 1'b0;
      penable          <= 1'b0;
      pwrite           <= 1'b0;
      paddr            <= '0;
      pwdata           <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset value of num_nodes is one slot
      send_request(OP_OPEN, 8'h00);
      send_request(OP_CLOSE, 8'h00);
      send_request(OP_CLOSE, 8'hFF);
      send_request(OP_OPEN, 8'hFF);
      send_request(OP_OPEN, 8'hFF);
      send_request(OP_CLOSE, 8'hFF);
      send_request(OP_CLOSE, 8'hFF);
      send_request(OP_OPEN, 8'hFF);
      send_request(OP_OPEN, 8'h01);
      send_request(OP_CLOSE, 8'h01);

      // nothing searched: every request misses
      set_num_nodes(NUM_NODES_W'(0));
      send_request(OP_OPEN, 8'hFF);
      send_request(OP_CLOSE, 8'hFF);
      send_request(OP_OPEN, 8'h01);

      // fill four slots, then lower num_nodes below the filled slots
      set_num_nodes(NUM_NODES_W'(4));
      send_request(OP_OPEN, 8'h01);
      send_request(OP_OPEN, 8'h80);
      send_request(OP_CLOSE, 8'h01);
      send_request(OP_CLOSE, 8'h80);
      send_request(OP_OPEN, 8'h55);
      send_request(OP_CLOSE, 8'h55);
      send_request(OP_OPEN, 8'hAA);
      set_num_nodes(NUM_NODES_W'(2));
      send_request(OP_CLOSE, 8'h01);
      send_request(OP_CLOSE, 8'h55);

      for (phase = 0; phase < 5; phase++) begin
         set_num_nodes(NUM_NODES_W'(random_settings[phase]));
         if (random_settings[phase] == TABLE_SLOTS)
            long_stall_armed = 1'b1;
         repeat (RANDOM_PER_PHASE)
            send_request(op_type'($urandom_range(0, 99) < 55), pick_node_id());
      end

      // hammer slot zero back to back
      set_num_nodes(NUM_NODES_W'(1));
      paced_sender = 1'b0;
      fast_drain   = 1'b1;
      for (n = 0; n < TAIL_CLOSES; n++)
         send_request(OP_CLOSE, 8'hFF);
      send_request(OP_OPEN, 8'hFF);
      send_request(OP_CLOSE, 8'hFF);
      send_request(OP_CLOSE, 8'hFF);
      send_request(OP_OPEN, 8'h55);

      drain_tally();
      repeat (TABLE_SLOTS + 8) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
